// ===== rtl/core/lzwd_pkg.sv =====
// lzwd_pkg: shared types and constants of the lzss window decoder
// no dependencies; used by the queue, front, back and top files and by the bench

package lzwd_pkg;

  // history window
  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned WIN_AW   = $clog2(HIST_DEPTH);
  localparam int unsigned FILL_W   = WIN_AW + 1;
  localparam logic [WIN_AW-1:0] WIN_START = 12'hFEE;

  // data and match fields
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam logic [LEN_W-1:0] MATCH_MIN = 5'd3;
  localparam int unsigned FLAG_W    = 9;
  localparam int unsigned COUNT_W   = 32;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LIT,
    CMD_MATCH
  } cmd_kind_t;

  typedef struct packed {
    logic                frame;
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   data;
    logic [WIN_AW-1:0]   pos;
    logic [LEN_W-1:0]    len;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_LIT,
    PH_MLOW,
    PH_MHIGH
  } fe_phase_t;

  typedef enum logic {
    BE_IDLE,
    BE_COPY
  } be_state_t;

endpackage

// ===== rtl/core/lzwd_in_if.sv =====
// lzwd_in_if: compressed byte channel, valid/ready handshake
// depends on nothing

interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_start;

  modport source (output valid, output in_byte, output frame_start, input ready);
  modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

// ===== rtl/core/lzwd_out_if.sv =====
// lzwd_out_if: decompressed byte channel, valid/ready handshake
// depends on nothing

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

// ===== rtl/core/lzwd_ram.sv =====
// lzwd_ram: generic single write port, single read port ram with registered read
// no package dependency

module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lzwd_cmd_fifo.sv =====
// lzwd_cmd_fifo: short command queue between parser and copy engine
// depends on lzwd_pkg (cmd_t)

module lzwd_cmd_fifo #(
  parameter int unsigned DEPTH = lzwd_pkg::CMD_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lzwd_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            pop,
  output logic            rvalid,
  output lzwd_pkg::cmd_t  rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lzwd_pkg::cmd_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign full   = (count_r == CW'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/lzwd_front.sv =====
// lzwd_front: takes compressed bytes, tracks flag bits and match tokens,
// and queues literal, match and frame commands; depends on lzwd_pkg, lzwd_in_if

module lzwd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_freeze,
  input  logic            len_zero,
  lzwd_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output lzwd_pkg::cmd_t  cmd
);

  lzwd_pkg::fe_phase_t                  phase_r, phase_nxt, phase_b;
  logic [lzwd_pkg::FLAG_W-1:0]          flag_r, flag_nxt, flag_b;
  logic [lzwd_pkg::BYTE_W-1:0]          low_r, low_nxt, low_b;
  logic                                 frozen_r, frozen_b;
  logic                                 accept;
  logic [lzwd_pkg::BYTE_W-1:0]          b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  // a frame start clears the parser before the byte is looked at
  assign phase_b = in_ch.frame_start ? lzwd_pkg::PH_TOKEN : phase_r;
  assign flag_b  = in_ch.frame_start ? '0 : flag_r;
  assign low_b   = in_ch.frame_start ? '0 : low_r;

  // stream with its count already at the length: bytes leave the parser as is
  assign frozen_b = in_ch.frame_start ? len_zero : frozen_r;

  // next state
  always_comb begin
    phase_nxt = phase_b;
    flag_nxt  = flag_b;
    low_nxt   = low_b;
    unique case (phase_b)
      lzwd_pkg::PH_TOKEN: begin
        if (flag_b[lzwd_pkg::FLAG_W-1:1] == '0) begin
          // new flag byte under a marker bit, first decision consumed now
          flag_nxt  = {2'b01, b[7:1]};
          phase_nxt = b[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_MLOW;
        end else begin
          flag_nxt = flag_b >> 1;
          if (!flag_b[0]) begin
            low_nxt   = b;
            phase_nxt = lzwd_pkg::PH_MHIGH;
          end
        end
      end
      lzwd_pkg::PH_LIT: begin
        phase_nxt = lzwd_pkg::PH_TOKEN;
      end
      lzwd_pkg::PH_MLOW: begin
        low_nxt   = b;
        phase_nxt = lzwd_pkg::PH_MHIGH;
      end
      lzwd_pkg::PH_MHIGH: begin
        phase_nxt = lzwd_pkg::PH_TOKEN;
      end
      default: begin
        phase_nxt = lzwd_pkg::PH_TOKEN;
      end
    endcase
    if (frozen_b) begin
      phase_nxt = phase_b;
      flag_nxt  = flag_b;
      low_nxt   = low_b;
    end
  end

  // command out
  always_comb begin
    cmd.frame = in_ch.frame_start;
    cmd.kind  = lzwd_pkg::CMD_NOP;
    cmd.data  = b;
    cmd.pos   = {b[7:4], low_b};
    cmd.len   = lzwd_pkg::LEN_W'(b[3:0]) + lzwd_pkg::MATCH_MIN;
    unique case (phase_b)
      lzwd_pkg::PH_TOKEN: begin
        if (flag_b[lzwd_pkg::FLAG_W-1:1] != '0 && flag_b[0]) begin
          cmd.kind = lzwd_pkg::CMD_LIT;
        end
      end
      lzwd_pkg::PH_LIT:   cmd.kind = lzwd_pkg::CMD_LIT;
      lzwd_pkg::PH_MLOW:  cmd.kind = lzwd_pkg::CMD_NOP;
      lzwd_pkg::PH_MHIGH: cmd.kind = lzwd_pkg::CMD_MATCH;
      default:            cmd.kind = lzwd_pkg::CMD_NOP;
    endcase
    if (frozen_b) begin
      cmd.kind = lzwd_pkg::CMD_NOP;
    end
    push = accept && (cmd.kind != lzwd_pkg::CMD_NOP || in_ch.frame_start);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lzwd_pkg::PH_TOKEN;
      flag_r  <= '0;
      low_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      low_r   <= low_nxt;
    end
  end

  // length is zero after reset, so the first stream starts frozen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r <= 1'b1;
    end else if (cfg_we) begin
      frozen_r <= cfg_freeze;
    end else if (accept) begin
      frozen_r <= frozen_b;
    end
  end

endmodule

// ===== rtl/core/lzwd_back.sv =====
// lzwd_back: executes queued commands, copies matches out of the history window,
// counts output against the configured length; depends on lzwd_pkg, lzwd_ram, lzwd_out_if

module lzwd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lzwd_pkg::COUNT_W-1:0]  cfg_wdata,
  output logic                          cfg_freeze,
  output logic                          len_zero,
  input  logic                          q_valid,
  input  lzwd_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          busy,
  lzwd_out_if.source                    out_ch
);

  localparam int unsigned AW = lzwd_pkg::WIN_AW;
  localparam int unsigned BW = lzwd_pkg::BYTE_W;
  localparam int unsigned CW = lzwd_pkg::COUNT_W;
  localparam int unsigned FW = lzwd_pkg::FILL_W;
  localparam int unsigned LW = lzwd_pkg::LEN_W;

  lzwd_pkg::be_state_t state_r, state_nxt;

  logic [CW-1:0] out_length_r;
  logic [CW-1:0] produced_r, produced_nxt;
  logic          finished_r, finished_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  // copy engine: read issue and data stage
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [LW-1:0] remain_r, remain_nxt;
  logic          dv_r, dv_nxt;
  logic          fwd_r, fwd_nxt;
  logic [BW-1:0] fwd_data_r, fwd_data_nxt;
  logic          hit_r, hit_nxt;
  logic          dlast_r, dlast_nxt;

  logic          out_valid_r;
  logic [BW-1:0] out_byte_r;
  logic          run_last_r;
  logic          stream_done_r;

  logic          out_free;
  logic          idle;
  logic          frm;
  logic [CW-1:0] prod_b, prod_inc;
  logic          fin_b;
  logic [AW-1:0] wp_b;
  logic [FW-1:0] fill_b;
  logic          dead;
  logic          lit_go, match_go;
  logic          dv_emit;
  logic          emit, done, emit_last;
  logic [BW-1:0] emit_byte, d_byte;
  logic          issue;
  logic [AW-1:0] rd_off;
  logic          ram_we;
  logic [BW-1:0] ram_rdata;

  assign out_free = !out_valid_r || out_ch.ready;

  // state the parser needs to know whether a stream is stuck at its length
  assign cfg_freeze = !finished_r && (produced_r >= cfg_wdata);
  assign len_zero   = (out_length_r == '0);

  // outputs of the control state
  always_comb begin
    idle  = (state_r == lzwd_pkg::BE_IDLE);
    q_pop = idle && q_valid && out_free;
    busy  = !idle;
  end

  // datapath
  always_comb begin
    frm    = q_pop && q_cmd.frame;
    prod_b = frm ? '0 : produced_r;
    fin_b  = frm ? 1'b0 : finished_r;
    wp_b   = frm ? lzwd_pkg::WIN_START : wp_r;
    fill_b = frm ? '0 : fill_r;
    dead   = fin_b || (prod_b >= out_length_r);

    lit_go   = q_pop && (q_cmd.kind == lzwd_pkg::CMD_LIT) && !dead;
    match_go = q_pop && (q_cmd.kind == lzwd_pkg::CMD_MATCH) && !dead;
    dv_emit  = dv_r && out_free;

    // never-written window entries read as zero
    d_byte    = fwd_r ? fwd_data_r : (hit_r ? ram_rdata : '0);
    emit      = lit_go || dv_emit;
    emit_byte = lit_go ? q_cmd.data : d_byte;
    prod_inc  = prod_b + 1'b1;
    done      = emit && (prod_inc == out_length_r);
    emit_last = lit_go || dlast_r || done;

    ram_we       = emit && !done;
    wp_nxt       = ram_we ? wp_b + 1'b1 : wp_b;
    fill_nxt     = (ram_we && !fill_b[FW-1]) ? fill_b + 1'b1 : fill_b;
    produced_nxt = emit ? prod_inc : prod_b;
    finished_nxt = fin_b || done;

    issue  = !idle && (remain_r != '0) && (!dv_r || dv_emit) && !done;
    rd_off = rd_addr_r - lzwd_pkg::WIN_START;

    rd_addr_nxt  = rd_addr_r;
    remain_nxt   = remain_r;
    dv_nxt       = dv_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    hit_nxt      = hit_r;
    dlast_nxt    = dlast_r;
    if (match_go) begin
      rd_addr_nxt = q_cmd.pos;
      remain_nxt  = q_cmd.len;
    end
    if (issue) begin
      rd_addr_nxt  = rd_addr_r + 1'b1;
      remain_nxt   = remain_r - 1'b1;
      dv_nxt       = 1'b1;
      // byte written this cycle at the address being read: forward it
      fwd_nxt      = ram_we && (wp_b == rd_addr_r);
      fwd_data_nxt = emit_byte;
      hit_nxt      = ({1'b0, rd_off} < fill_r);
      dlast_nxt    = (remain_r == LW'(1));
    end else if (dv_emit) begin
      dv_nxt = 1'b0;
    end
    // a match cut short at the end of the stream drops the rest
    if (done) begin
      remain_nxt = '0;
      dv_nxt     = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwd_pkg::BE_IDLE: begin
        if (match_go) begin
          state_nxt = lzwd_pkg::BE_COPY;
        end
      end
      lzwd_pkg::BE_COPY: begin
        if (remain_nxt == '0 && !dv_nxt) begin
          state_nxt = lzwd_pkg::BE_IDLE;
        end
      end
      default: state_nxt = lzwd_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzwd_pkg::BE_IDLE;
      out_length_r <= '0;
      produced_r   <= '0;
      finished_r   <= 1'b0;
      wp_r         <= lzwd_pkg::WIN_START;
      fill_r       <= '0;
      remain_r     <= '0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      produced_r <= produced_nxt;
      finished_r <= finished_nxt;
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      remain_r   <= remain_nxt;
      dv_r       <= dv_nxt;
      if (cfg_we) begin
        out_length_r <= cfg_wdata;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    fwd_r      <= fwd_nxt;
    fwd_data_r <= fwd_data_nxt;
    hit_r      <= hit_nxt;
    dlast_r    <= dlast_nxt;
    if (emit) begin
      out_byte_r    <= emit_byte;
      run_last_r    <= emit_last;
      stream_done_r <= done;
    end
  end

  lzwd_ram #(
    .WIDTH (BW),
    .DEPTH (lzwd_pkg::HIST_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_b),
    .wdata (emit_byte),
    .re    (issue),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.stream_done = stream_done_r;

endmodule

// ===== rtl/core/lzss_window_decoder.sv =====
// lzss_window_decoder: lzss decoder with a 4096-byte history window.
// a literal goes through the command queue and output register, a match byte through
// the queue, read address register, window ram and output register, one ram read per
// output byte. input takes 1 byte per cycle while the command queue has room; the
// copy engine finishes each match before a new command. reset and frame start clear the
// window through a fill count, with no clearing pass; synchronous active-low reset

module lzss_window_decoder #(
  parameter int unsigned CMD_DEPTH = lzwd_pkg::CMD_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lzwd_pkg::COUNT_W-1:0]  cfg_wdata,
  lzwd_in_if.sink                       in_ch,
  lzwd_out_if.source                    out_ch
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  logic           be_busy;
  logic           be_cfg_freeze;
  logic           be_len_zero;
  lzwd_pkg::cmd_t fe_cmd;
  lzwd_pkg::cmd_t q_cmd;

  lzwd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_freeze (be_cfg_freeze),
    .len_zero   (be_len_zero),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (q_push),
    .cmd        (fe_cmd)
  );

  lzwd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (fe_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_cmd)
  );

  lzwd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cfg_freeze (be_cfg_freeze),
    .len_zero   (be_len_zero),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .busy       (be_busy),
    .out_ch     (out_ch)
  );

  // queue never popped empty or pushed full
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("command popped from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command pushed into full queue");

  // a new command is only taken once the copy engine has drained
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !be_busy) else $error("command popped during a match copy");

  // the byte that ends the stream also ends its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stream_done) |-> out_ch.run_last)
    else $error("stream_done without run_last");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for lzss_window_decoder, directed then random token streams
// depends on lzwd_pkg, lzwd_in_if, lzwd_out_if and the decoder rtl

import lzwd_pkg::*;

typedef struct {
  logic [BYTE_W-1:0] data;
  logic              last;
  logic              done;
} dec_byte_t;

// tracks the decoder state and holds the decompressed bytes still to come
class decode_tracker;
  logic [BYTE_W-1:0]  hist [HIST_DEPTH];
  logic [WIN_AW-1:0]  wr_ptr;
  logic [FLAG_W-1:0]  flags;
  fe_phase_t          phase;
  logic [BYTE_W-1:0]  low_byte;
  logic [COUNT_W-1:0] produced;
  logic [COUNT_W-1:0] out_len;
  logic               finished;
  dec_byte_t          awaited [$];
  dec_byte_t          step_q [$];
  int unsigned        errors;

  function new();
    clear_stream();
    out_len = '0;
    errors = 0;
  endfunction

  function void clear_stream();
    foreach (hist[i]) hist[i] = '0;
    wr_ptr = WIN_START;
    flags = '0;
    phase = PH_TOKEN;
    low_byte = '0;
    produced = '0;
    finished = 1'b0;
  endfunction

  // returns 1 when this byte completes the stream
  function bit put_byte(logic [BYTE_W-1:0] d);
    dec_byte_t r;
    r.data = d;
    r.last = 1'b0;
    r.done = 1'b0;
    produced = produced + 1'b1;
    if (produced >= out_len) begin
      r.done = 1'b1;
      finished = 1'b1;
      step_q.push_back(r);
      return 1'b1;
    end
    step_q.push_back(r);
    hist[wr_ptr] = d;
    wr_ptr = wr_ptr + 1'b1;
    return 1'b0;
  endfunction

  function void take_token(logic [BYTE_W-1:0] b, logic fs);
    logic              lit;
    logic [WIN_AW-1:0] rd;
    int unsigned       len;
    step_q.delete();
    if (fs) clear_stream();
    if (finished || produced >= out_len) return;
    case (phase)
      PH_TOKEN: begin
        if (flags <= 1) begin
          flags = {1'b1, b};
          phase = flags[0] ? PH_LIT : PH_MLOW;
          flags = flags >> 1;
        end else begin
          lit = flags[0];
          flags = flags >> 1;
          if (lit) begin
            void'(put_byte(b));
          end else begin
            low_byte = b;
            phase = PH_MHIGH;
          end
        end
      end
      PH_LIT: begin
        void'(put_byte(b));
        phase = PH_TOKEN;
      end
      PH_MLOW: begin
        low_byte = b;
        phase = PH_MHIGH;
      end
      default: begin
        rd = {b[7:4], low_byte};
        len = b[3:0] + 3;
        phase = PH_TOKEN;
        // window is read live, so overlapping copies repeat fresh bytes
        for (int i = 0; i < len; i++) begin
          if (put_byte(hist[rd])) break;
          rd = rd + 1'b1;
        end
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) awaited.push_back(step_q[i]);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task check_byte(logic [BYTE_W-1:0] d, logic rl, logic sd);
    dec_byte_t e;
    if (awaited.size() == 0) begin
      report($sformatf("output transfer %02h with nothing expected", d));
      return;
    end
    e = awaited.pop_front();
    if (d !== e.data) report($sformatf("out_byte %02h, expected %02h", d, e.data));
    if (rl !== e.last) report($sformatf("run_last %b, expected %b", rl, e.last));
    if (sd !== e.done) report($sformatf("stream_done %b, expected %b", sd, e.done));
  endtask
endclass

module tb;
  localparam int HALF         = 6;
  localparam int SETTLE       = 128;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 125;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              fs;
  } token_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  lzwd_in_if  in_ch();
  lzwd_out_if out_ch();

  decode_tracker tracker = new();
  token_t        token_q [$];
  bit            hold_req = 1'b0;
  bit            calm = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   quiet = 0;

  always #HALF clk = ~clk;

  lzss_window_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else begin
        if (stall_left == 0) begin
          if (hold_req) begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD;
          end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6);
          end
        end
        out_ch.ready = (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_byte(out_ch.out_byte, out_ch.run_last, out_ch.stream_done);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[lzss_window_decoder] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_tok(input logic [BYTE_W-1:0] b, input logic fs);
    token_t t;
    t.b = b;
    t.fs = fs;
    token_q.push_back(t);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.in_byte = b;
    in_ch.frame_start = fs;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_token(b, fs);
    @(negedge clk);
  endtask

  task automatic send_tokens(input int pause_at);
    token_t t;
    int     idx;
    idx = 0;
    while (token_q.size() != 0) begin
      if (idx == pause_at) begin
        in_ch.valid = 1'b0;
        while (tracker.awaited.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      t = token_q.pop_front();
      send_byte(t.b, t.fs);
      idx++;
    end
    in_ch.valid = 1'b0;
  endtask

  // flag-only and first-match-byte transfers give no output, so allow extra cycles
  task automatic wait_quiet();
    while (tracker.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_out_length(input logic [COUNT_W-1:0] v);
    wait_quiet();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    tracker.out_len = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // well-formed stream: flag byte, then literals and matches, frame start on first byte
  task automatic build_stream(input int unsigned ntok, input bit near);
    logic [7:0]  fl;
    logic [11:0] pos;
    logic [3:0]  mlen;
    int unsigned filled;
    int unsigned left;
    logic        first;
    filled = 0;
    left = ntok;
    first = 1'b1;
    while (left > 0) begin
      fl = 8'($urandom_range(0, 255));
      push_tok(fl, first);
      first = 1'b0;
      for (int k = 0; k < 8 && left > 0; k++) begin
        left--;
        if (fl[k]) begin
          push_tok(8'($urandom_range(0, 255)), 1'b0);
          filled++;
        end else begin
          mlen = 4'($urandom_range(0, 15));
          // mostly point back into bytes already produced
          if (near && filled > 0) pos = 12'(WIN_START + $urandom_range(0, filled - 1));
          else pos = 12'($urandom_range(0, HIST_DEPTH - 1));
          push_tok(pos[7:0], 1'b0);
          push_tok({pos[11:8], mlen}, 1'b0);
          filled += mlen + 3;
        end
      end
    end
  endtask

  task automatic build_noise(input int unsigned n);
    repeat (n) push_tok(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
  endtask

  initial begin
    int unsigned        random_sent;
    int unsigned        phase_no;
    int unsigned        mode;
    int                 pause_at;
    logic [COUNT_W-1:0] len;

    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.frame_start = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // zero length: nothing comes out
    write_out_length('0);
    push_tok(8'h00, 1'b1);
    push_tok(8'hFF, 1'b0);
    push_tok(8'h41, 1'b0);
    send_tokens(-1);

    // literal, shortest and longest matches, window edges, match cut at the end
    write_out_length(32'd30);
    push_tok(8'h01, 1'b1);
    push_tok(8'hFF, 1'b0);
    push_tok(8'hEE, 1'b0);
    push_tok(8'hF0, 1'b0);
    push_tok(8'h00, 1'b0);
    push_tok(8'h0F, 1'b0);
    push_tok(8'hFF, 1'b0);
    push_tok(8'hFF, 1'b0);
    // past the end: ignored until a frame start
    push_tok(8'hAB, 1'b0);
    push_tok(8'h12, 1'b0);
    send_tokens(-1);

    // all-match flag byte, largest length
    write_out_length('1);
    push_tok(8'h00, 1'b1);
    push_tok(8'hEE, 1'b0);
    push_tok(8'h02, 1'b0);
    push_tok(8'h01, 1'b0);
    push_tok(8'h10, 1'b0);
    send_tokens(-1);

    // length dropped below the count, then a short stream ending on a literal
    write_out_length(32'd2);
    push_tok(8'h55, 1'b0);
    push_tok(8'hFF, 1'b1);
    push_tok(8'h80, 1'b0);
    push_tok(8'h7F, 1'b0);
    push_tok(8'h33, 1'b0);
    send_tokens(-1);

    random_sent = 0;
    phase_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= RANDOM_ITEMS - 35);
      pause_at = -1;
      if (phase_no == 2) begin
        write_out_length('1);
        build_stream(14, 1'b1);
        hold_req = 1'b1;
      end else if (phase_no == 4) begin
        write_out_length(32'($urandom_range(40, 200)));
        build_stream(10, 1'b1);
        pause_at = token_q.size() / 2;
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 2) len = 32'($urandom_range(1, 4));
        else if (mode < 8) len = 32'($urandom_range(5, 120));
        else len = '1;
        write_out_length(len);
        if (mode == 9) build_noise($urandom_range(3, 10));
        else build_stream($urandom_range(2, 12), $urandom_range(0, 3) != 0);
      end
      random_sent += token_q.size();
      send_tokens(pause_at);
      phase_no++;
    end

    wait_quiet();
    if (tracker.errors == 0) begin
      $display("[lzss_window_decoder] OK");
    end else begin
      $display("[lzss_window_decoder] ERROR");
    end
    $finish;
  end
endmodule
